FILE: hdl/dq_pkg.sv
// package for the double-ended queue: sizes, operation and error codes,
// and the control bundle passed from pointer logic to the storage side
// no dependencies
package dq_pkg;

  localparam int DQ_DEPTH  = 16;
  localparam int DQ_DATA_W = 32;
  localparam int DQ_ADDR_W = $clog2(DQ_DEPTH);
  localparam int DQ_CNT_W  = $clog2(DQ_DEPTH + 1);

  typedef logic [DQ_ADDR_W-1:0] dq_addr_t;
  typedef logic [DQ_CNT_W-1:0]  dq_cnt_t;
  typedef logic signed [DQ_DATA_W-1:0] dq_data_t;

  typedef enum logic [2:0] {
    DQ_PUSH_FRONT = 3'd0,
    DQ_PUSH_BACK  = 3'd1,
    DQ_POP_FRONT  = 3'd2,
    DQ_POP_BACK   = 3'd3,
    DQ_PEEK_FRONT = 3'd4,
    DQ_PEEK_BACK  = 3'd5
  } dq_op_t;

  typedef enum logic [1:0] {
    DQ_ERR_NONE  = 2'd0,
    DQ_ERR_UNDER = 2'd1,
    DQ_ERR_OVER  = 2'd2
  } dq_err_t;

  typedef struct packed {
    logic     mem_we;
    logic     mem_re;
    dq_addr_t addr;
    dq_cnt_t  count_next;
    dq_err_t  err;
  } dq_ctl_t;

endpackage

FILE: hdl/dq_ptr.sv
// front pointer and element count of the ring, plus decode of one operation
// into a storage access, new count and error code
// depends on dq_pkg
module dq_ptr (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  dq_pkg::dq_op_t  op,
  output dq_pkg::dq_ctl_t ctl
);
  import dq_pkg::*;

  dq_addr_t front, front_next;
  dq_cnt_t  elems;

  // (base + off) mod depth, correct only for off not above depth
  function automatic dq_addr_t ring_add(dq_addr_t base, dq_cnt_t off);
    logic [DQ_CNT_W:0] s;
    s = (DQ_CNT_W + 1)'(base) + (DQ_CNT_W + 1)'(off);
    if (s >= (DQ_CNT_W + 1)'(DQ_DEPTH)) begin
      s = s - (DQ_CNT_W + 1)'(DQ_DEPTH);
    end
    return s[DQ_ADDR_W-1:0];
  endfunction

  logic     is_full, ring_empty;
  dq_addr_t front_dec, front_inc, back_slot, push_back_slot;

  assign is_full        = (elems == DQ_CNT_W'(DQ_DEPTH));
  assign ring_empty     = (elems == '0);
  assign front_dec      = (front == '0) ? DQ_ADDR_W'(DQ_DEPTH - 1) : front - 1'b1;
  assign front_inc      = (front == DQ_ADDR_W'(DQ_DEPTH - 1)) ? '0 : front + 1'b1;
  assign back_slot      = ring_add(front, elems - 1'b1);
  assign push_back_slot = ring_add(front, elems);

  // operation decode
  always_comb begin
    ctl            = '0;
    ctl.count_next = elems;
    ctl.err        = DQ_ERR_NONE;
    front_next     = front;
    unique case (op)
      DQ_PUSH_FRONT: begin
        if (is_full) begin
          ctl.err = DQ_ERR_OVER;
        end else begin
          front_next     = front_dec;
          ctl.mem_we     = 1'b1;
          ctl.addr       = front_dec;
          ctl.count_next = elems + 1'b1;
        end
      end
      DQ_PUSH_BACK: begin
        if (is_full) begin
          ctl.err = DQ_ERR_OVER;
        end else begin
          ctl.mem_we     = 1'b1;
          ctl.addr       = push_back_slot;
          ctl.count_next = elems + 1'b1;
        end
      end
      DQ_POP_FRONT: begin
        if (ring_empty) begin
          ctl.err = DQ_ERR_UNDER;
        end else begin
          front_next     = front_inc;
          ctl.mem_re     = 1'b1;
          ctl.addr       = front;
          ctl.count_next = elems - 1'b1;
        end
      end
      DQ_POP_BACK: begin
        if (ring_empty) begin
          ctl.err = DQ_ERR_UNDER;
        end else begin
          ctl.mem_re     = 1'b1;
          ctl.addr       = back_slot;
          ctl.count_next = elems - 1'b1;
        end
      end
      DQ_PEEK_FRONT: begin
        if (ring_empty) begin
          ctl.err = DQ_ERR_UNDER;
        end else begin
          ctl.mem_re = 1'b1;
          ctl.addr   = front;
        end
      end
      DQ_PEEK_BACK: begin
        if (ring_empty) begin
          ctl.err = DQ_ERR_UNDER;
        end else begin
          ctl.mem_re = 1'b1;
          ctl.addr   = back_slot;
        end
      end
      default: begin
        ctl.err = DQ_ERR_NONE;
      end
    endcase
  end

  // pointer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      elems <= '0;
    end else if (accept) begin
      front <= front_next;
      elems <= ctl.count_next;
    end
  end

  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    elems <= DQ_CNT_W'(DQ_DEPTH))
    else $error("element count beyond capacity");

  // an accepted write grows the count by one
  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl.mem_we) |=> (elems == $past(elems) + 1'b1))
    else $error("push did not grow count");

  // errors leave pointer and count alone
  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl.err != DQ_ERR_NONE) |=> ($stable(elems) && $stable(front)))
    else $error("failed operation changed state");

endmodule

FILE: hdl/double_ended_queue_top.sv
// top level of the double-ended queue: ring storage memory, pointer logic
// and the result register
// depends on dq_pkg and dq_ptr
//
// usage:
//   input channel: in_valid / in_stall with opcode and value_in. opcode
//   selects push front, push back, pop front, pop back, peek front or
//   peek back; value_in is used by pushes only.
//   output channel: out_valid / out_stall with value_out, count,
//   empty_res and error_code, exactly one result per input transaction.
//   result: a result appears in the cycle after its transaction is accepted,
//   taken from the registered read of the storage memory.
//   throughput: one transaction per cycle barring stalls; pointer and count
//   update at the accepting edge; writes land in memory before later reads.
//   stall: while out_stall holds a pending result, in_stall is raised and
//   the result register and its read data stay unchanged.
//   reset: rst (synchronous) empties the queue and drops any pending
//   result; storage contents are not cleared and are never read before
//   being written.
//   errors: pop or peek on an empty queue reports underflow, push into a
//   full queue reports overflow; both leave the queue unchanged.
module double_ended_queue_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  dq_pkg::dq_data_t  value_in,
  output logic              out_valid,
  input  logic              out_stall,
  output dq_pkg::dq_data_t  value_out,
  output dq_pkg::dq_cnt_t   count,
  output logic              empty_res,
  output logic [1:0]        error_code
);
  import dq_pkg::*;

  dq_data_t mem [DQ_DEPTH];
  dq_data_t rd_data;
  dq_ctl_t  ctl;
  logic     accept;
  logic     res_read;
  dq_cnt_t  res_count;
  dq_err_t  res_err;

  // the result register frees when empty or taken this cycle
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  dq_ptr u_ptr (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .op     (dq_op_t'(opcode)),
    .ctl    (ctl)
  );

  // ring storage, at most one access per transaction
  always_ff @(posedge clk) begin
    if (accept && ctl.mem_we) begin
      mem[ctl.addr] <= value_in;
    end
    if (accept && ctl.mem_re) begin
      rd_data <= mem[ctl.addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_read  <= ctl.mem_re;
      res_count <= ctl.count_next;
      res_err   <= ctl.err;
    end
  end

  // output fields
  assign value_out  = res_read ? rd_data : '0;
  assign count      = res_count;
  assign empty_res  = (res_count == '0);
  assign error_code = res_err;

  // every accepted transaction yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  // failed operations return zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_err != DQ_ERR_NONE) |-> (value_out == '0))
    else $error("nonzero value on error result");

  // overflow is only reported with a full queue
  a_over_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_err == DQ_ERR_OVER) |-> (res_count == DQ_CNT_W'(DQ_DEPTH)))
    else $error("overflow reported below capacity");

endmodule

FILE: test/deque_result_checker.sv
// result checker for the double-ended queue: tracks the ring contents on every
// accepted transaction and compares each delivered result with the oldest one owed
// depends on dq_pkg
module deque_result_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        opcode,
  input  dq_pkg::dq_data_t  value_in,
  input  logic              out_valid,
  input  logic              out_stall,
  input  dq_pkg::dq_data_t  value_out,
  input  dq_pkg::dq_cnt_t   count,
  input  logic              empty_res,
  input  logic [1:0]        error_code,
  output int                mismatches,
  output int                ops_taken,
  output int                results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;

  typedef struct {
    dq_data_t value;
    dq_cnt_t  level;
    logic     empty_flag;
    dq_err_t  err;
  } deque_result_t;

  // shadow copy of the ring and its pointers
  dq_data_t ring [DQ_DEPTH];
  int head = 0;
  int fill = 0;

  deque_result_t owed_results[$];
  int fails = 0;
  int taken = 0;
  int owed = 0;

  assign mismatches   = fails;
  assign ops_taken    = taken;
  assign results_owed = owed;

  // apply one operation to the shadow deque and return the result it should give
  function automatic deque_result_t apply_deque_op(logic [2:0] op, dq_data_t val);
    deque_result_t r;
    int tail;
    r.value = '0;
    r.err   = DQ_ERR_NONE;
    tail    = (head + fill - 1 + DQ_DEPTH) % DQ_DEPTH;
    case (op)
      DQ_PUSH_FRONT: begin
        if (fill >= DQ_DEPTH) begin
          r.err = DQ_ERR_OVER;
        end else begin
          head = (head == 0) ? DQ_DEPTH - 1 : head - 1;
          ring[head] = val;
          fill++;
        end
      end
      DQ_PUSH_BACK: begin
        if (fill >= DQ_DEPTH) begin
          r.err = DQ_ERR_OVER;
        end else begin
          fill++;
          ring[(head + fill - 1) % DQ_DEPTH] = val;
        end
      end
      DQ_POP_FRONT: begin
        if (fill == 0) begin
          r.err = DQ_ERR_UNDER;
        end else begin
          r.value = ring[head];
          head = (head == DQ_DEPTH - 1) ? 0 : head + 1;
          fill--;
        end
      end
      DQ_POP_BACK: begin
        if (fill == 0) begin
          r.err = DQ_ERR_UNDER;
        end else begin
          r.value = ring[tail];
          fill--;
        end
      end
      DQ_PEEK_FRONT: begin
        if (fill == 0) r.err = DQ_ERR_UNDER;
        else r.value = ring[head];
      end
      DQ_PEEK_BACK: begin
        if (fill == 0) r.err = DQ_ERR_UNDER;
        else r.value = ring[tail];
      end
      default: ;
    endcase
    r.level      = dq_cnt_t'(fill);
    r.empty_flag = (fill == 0);
    return r;
  endfunction

  // watch both channels at the rising edge; results are checked before the new
  // transaction is queued, since a result never leaves in its own accept cycle
  always @(posedge clk) begin : watch
    deque_result_t want;
    if (rst) begin
      head = 0;
      fill = 0;
      owed_results.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: value_out %0d count %0d empty_res %0b error_code %0d",
                 value_out, count, empty_res, error_code);
          fails++;
        end else begin
          want = owed_results.pop_front();
          if (value_out !== want.value) begin
            $error("value_out: expected %0d, got %0d", want.value, value_out);
            fails++;
          end
          if (count !== want.level) begin
            $error("count: expected %0d, got %0d", want.level, count);
            fails++;
          end
          if (empty_res !== want.empty_flag) begin
            $error("empty_res: expected %0b, got %0b", want.empty_flag, empty_res);
            fails++;
          end
          if (error_code !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, error_code);
            fails++;
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        owed_results.push_back(apply_deque_op(opcode, value_in));
        taken++;
      end
    end
    owed = owed_results.size();
  end

endmodule

FILE: test/double_ended_queue_top_tb.sv
// testbench top for the double-ended queue: clock, reset, stimulus and verdict
// depends on dq_pkg, double_ended_queue_top and deque_result_checker
module double_ended_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;

  localparam int RANDOM_OPS  = 950;
  localparam int CYCLE_LIMIT = 600000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       out_stall = 1'b0;
  logic [2:0] opcode = DQ_PEEK_FRONT;
  dq_data_t   value_in = '0;
  logic       in_stall;
  logic       out_valid;
  dq_data_t   value_out;
  dq_cnt_t    count;
  logic       empty_res;
  logic [1:0] error_code;

  int mismatches;
  int ops_taken;
  int results_owed;
  int cycles = 0;

  double_ended_queue_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .value_in   (value_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value_out  (value_out),
    .count      (count),
    .empty_res  (empty_res),
    .error_code (error_code)
  );

  deque_result_checker results_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .value_in     (value_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value_out    (value_out),
    .count        (count),
    .empty_res    (empty_res),
    .error_code   (error_code),
    .mismatches   (mismatches),
    .ops_taken    (ops_taken),
    .results_owed (results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run-length guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("double_ended_queue_top regression: fail");
      $finish;
    end
  end

  // idle stretch length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 25);
  endfunction

  function automatic int send_gap(bit calm);
    if (calm || $urandom_range(99) < 65) return 0;
    return idle_len();
  endfunction

  // value mix: extremes, zero, minus one and random words
  function automatic dq_data_t pick_value();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return '0;
      default: return dq_data_t'($urandom);
    endcase
  endfunction

  // present one transaction and hold it until accepted; called at a falling edge
  task automatic send_op(input logic [2:0] op, input dq_data_t val, input int gap);
    int target;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode   = op;
    value_in = val;
    in_valid = 1'b1;
    target   = ops_taken + 1;
    do @(negedge clk); while (ops_taken < target);
  endtask

  // hold off the sender until every owed result has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // receiver stall pattern, with calm stretches of no stall
  initial begin : stall_gen
    int left;
    int phase_left;
    bit calm;
    left = 0;
    phase_left = 0;
    calm = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        calm = ($urandom_range(3) == 0);
        phase_left = $urandom_range(300, 100);
      end
      phase_left--;
      if (left == 0 && !calm && $urandom_range(99) < 25) left = idle_len();
      out_stall = (left > 0);
      if (left > 0) left--;
    end
  end

  initial begin : stimulus
    dq_op_t put_ops [2] = '{DQ_PUSH_FRONT, DQ_PUSH_BACK};
    dq_op_t take_ops [4] = '{DQ_POP_FRONT, DQ_POP_BACK, DQ_PEEK_FRONT, DQ_PEEK_BACK};
    dq_op_t op;
    dq_data_t val;
    int sent;
    int batch_len;
    int push_pct;
    bit calm;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty access, fill to capacity with extremes, overflow both ends,
    // then both peeks and a pop front on the full queue, and a pop back
    calm = 1'b0;
    send_op(DQ_POP_BACK, 32'sd5, send_gap(calm));
    send_op(DQ_PEEK_FRONT, -32'sd5, send_gap(calm));
    for (int i = 0; i < DQ_DEPTH; i++) begin
      case (i)
        0: val = 32'sh8000_0000;
        1: val = 32'sh7fff_ffff;
        2: val = -32'sd1;
        3: val = '0;
        default: val = dq_data_t'($urandom);
      endcase
      send_op(put_ops[i % 2], val, send_gap(calm));
    end
    send_op(DQ_PUSH_FRONT, 32'sh1234_5678, send_gap(calm));
    send_op(DQ_PUSH_BACK, -32'sh1234_5678, send_gap(calm));
    send_op(DQ_PEEK_FRONT, '0, send_gap(calm));
    send_op(DQ_PEEK_BACK, '0, send_gap(calm));
    send_op(DQ_POP_FRONT, '0, send_gap(calm));
    send_op(DQ_POP_BACK, '0, send_gap(calm));
    wait_drained();

    // random batches biased toward filling, draining or a balanced mix, so the
    // pointers wrap and the queue hits both full and empty many times
    sent = 0;
    while (sent < RANDOM_OPS) begin
      batch_len = $urandom_range(80, 20);
      case ($urandom_range(2))
        0: push_pct = 80;
        1: push_pct = 20;
        default: push_pct = 50;
      endcase
      calm = ($urandom_range(3) == 0);
      repeat (batch_len) begin
        if ($urandom_range(99) < push_pct) op = put_ops[$urandom_range(1)];
        else op = take_ops[$urandom_range(3)];
        send_op(op, pick_value(), send_gap(calm));
        sent++;
      end
      if ($urandom_range(3) == 0) wait_drained();
    end

    // let the last results drain out
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("double_ended_queue_top regression: pass");
    end else begin
      $display("double_ended_queue_top regression: fail");
    end
    $finish;
  end

endmodule
